>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SIDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that an expression is never true outside reset.
`define SIDA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

>>> src/sida_pkg.sv
`timescale 1ns / 1ps

package sida_pkg;

  // Fixed widths and character codes
  localparam int ValueW    = 32;
  localparam int NumDigits = 10;
  localparam int BcdW      = 4 * NumDigits;
  localparam int CntW      = $clog2(ValueW);
  localparam int DigW      = 4;
  localparam int CharW     = 6;

  localparam logic [CharW-1:0] CharMinus = 6'd45;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  // Microprogram layout
  localparam int UcodeDepth = 5;
  localparam int PcW        = $clog2(UcodeDepth);

  localparam logic [PcW-1:0] PcLoad   = PcW'(0);
  localparam logic [PcW-1:0] PcDabble = PcW'(1);
  localparam logic [PcW-1:0] PcSkip   = PcW'(2);
  localparam logic [PcW-1:0] PcSign   = PcW'(3);
  localparam logic [PcW-1:0] PcEmit   = PcW'(4);

  // Datapath operations
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DABBLE,
    OP_SKIP,
    OP_SIGN,
    OP_EMIT
  } op_e;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_CNT_NZ,
    COND_LEAD_ZERO,
    COND_MORE
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] jump;
    logic [PcW-1:0] next;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    op_e  op;
    logic fire;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic cnt_nz;
    logic lead_zero;
    logic more;
    logic neg;
  } status_t;

  // Character leaving the datapath
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] char_code;
    logic             last;
    logic [DigW-1:0]  count;
  } emit_t;

  // Control store: one word per step
  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      PcLoad:   w = '{op: OP_LOAD,   cond: COND_NEVER,     jump: PcLoad,   next: PcDabble};
      PcDabble: w = '{op: OP_DABBLE, cond: COND_CNT_NZ,    jump: PcDabble, next: PcSkip};
      PcSkip:   w = '{op: OP_SKIP,   cond: COND_LEAD_ZERO, jump: PcSkip,   next: PcSign};
      PcSign:   w = '{op: OP_SIGN,   cond: COND_NEVER,     jump: PcSign,   next: PcEmit};
      PcEmit:   w = '{op: OP_EMIT,   cond: COND_MORE,      jump: PcEmit,   next: PcLoad};
      default:  w = '{op: OP_LOAD,   cond: COND_NEVER,     jump: PcLoad,   next: PcLoad};
    endcase
    return w;
  endfunction

endpackage

>>> src/sida_useq.sv
`timescale 1ns / 1ps

module sida_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  input  sida_pkg::status_t status_i,
  output sida_pkg::ctrl_t   ctrl_o
);
  import sida_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  uword_t         uw;
  logic           fire;
  logic           taken;

  // Fetch the control word of the current step
  assign uw = ucode_rom(pc_q);

  // A step completes when its handshake side allows it
  always_comb begin
    unique case (uw.op)
      OP_LOAD: fire = in_valid_i;
      OP_SIGN: fire = !status_i.neg || out_free_i;
      OP_EMIT: fire = out_free_i;
      default: fire = 1'b1;
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      COND_CNT_NZ:    taken = status_i.cnt_nz;
      COND_LEAD_ZERO: taken = status_i.lead_zero;
      COND_MORE:      taken = status_i.more;
      default:        taken = 1'b0;
    endcase
  end

  // Advance, jump or hold the step counter
  always_comb begin
    pc_d = pc_q;
    if (fire) begin
      pc_d = taken ? uw.jump : uw.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcLoad;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op   = uw.op;
  assign ctrl_o.fire = fire;

endmodule

>>> src/sida_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sida_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sida_pkg::ctrl_t                     ctrl_i,
  input  logic signed [sida_pkg::ValueW-1:0]  value_i,
  output sida_pkg::status_t                   status_o,
  output sida_pkg::emit_t                     emit_o
);
  import sida_pkg::*;

  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [BcdW-1:0]   adj;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DigW-1:0]   ndig_q, ndig_d;
  logic [DigW-1:0]   tot_q, tot_d;
  logic              neg_q, neg_d;
  logic [ValueW-1:0] raw;
  logic [DigW-1:0]   top;
  logic [DigW-1:0]   dig;

  assign raw = $unsigned(value_i);
  assign top = bcd_q[BcdW-1 -: DigW];

  // Add three to every digit of five or more before the shift
  always_comb begin
    adj = bcd_q;
    dig = '0;
    for (int i = 0; i < NumDigits; i++) begin
      dig = bcd_q[DigW*i +: DigW];
      adj[DigW*i +: DigW] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  // Next state for the operation of this step
  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    ndig_d = ndig_q;
    tot_d  = tot_q;
    neg_d  = neg_q;
    if (ctrl_i.fire) begin
      unique case (ctrl_i.op)
        OP_LOAD: begin
          neg_d  = raw[ValueW-1];
          mag_d  = raw[ValueW-1] ? (~raw + ValueW'(1)) : raw;
          bcd_d  = '0;
          cnt_d  = CntW'(ValueW - 1);
          ndig_d = DigW'(NumDigits);
        end
        OP_DABBLE: begin
          bcd_d = {adj[BcdW-2:0], mag_q[ValueW-1]};
          mag_d = {mag_q[ValueW-2:0], 1'b0};
          cnt_d = cnt_q - CntW'(1);
        end
        OP_SKIP: begin
          if (status_o.lead_zero) begin
            bcd_d  = {bcd_q[BcdW-DigW-1:0], {DigW{1'b0}}};
            ndig_d = ndig_q - DigW'(1);
          end
        end
        OP_SIGN: begin
          tot_d = ndig_q + {{(DigW-1){1'b0}}, neg_q};
        end
        OP_EMIT: begin
          bcd_d  = {bcd_q[BcdW-DigW-1:0], {DigW{1'b0}}};
          ndig_d = ndig_q - DigW'(1);
        end
        default: begin
          bcd_d = bcd_q;
        end
      endcase
    end
  end

  // Hold control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ndig_q <= DigW'(NumDigits);
      tot_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ndig_q <= ndig_d;
      tot_q  <= tot_d;
      neg_q  <= neg_d;
    end
  end

  // Hold the working value and the digits
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  // Report status to the sequencer
  assign status_o.cnt_nz    = (cnt_q != '0);
  assign status_o.more      = (ndig_q != DigW'(1));
  assign status_o.lead_zero = (top == '0) && status_o.more;
  assign status_o.neg       = neg_q;

  // Drive the character of this step
  always_comb begin
    emit_o.valid     = ctrl_i.fire &&
                       ((ctrl_i.op == OP_SIGN && neg_q) || ctrl_i.op == OP_EMIT);
    emit_o.char_code = (ctrl_i.op == OP_SIGN) ? CharMinus
                                              : CharZero + {{(CharW-DigW){1'b0}}, top};
    emit_o.last      = (ctrl_i.op == OP_EMIT) && !status_o.more;
    emit_o.count     = emit_o.last ? tot_q : '0;
  end

  `SIDA_ASSERT(a_ndig_range, ctrl_i.op != OP_LOAD |-> ndig_q >= 4'd1 && ndig_q <= 4'd10, "digit count out of range")
  `SIDA_ASSERT(a_emit_digit, ctrl_i.fire && ctrl_i.op == OP_EMIT |-> top <= 4'd9, "emitted digit above nine")
  `SIDA_ASSERT(a_dabble_end, ctrl_i.fire && ctrl_i.op == OP_DABBLE && !status_o.cnt_nz |=> mag_q == '0, "bits left after conversion")

endmodule

>>> src/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    value_i (32b signed)
// output    out_valid_o / out_stall_i  char_code_o (6b), last_o, char_count_o (4b)
//
// From acceptance to its last character an item passes through one load step,
// 32 shift-and-adjust steps, 11 steps split between leading-zero skips and digit emits,
// and one sign step. Characters leave one per cycle while the output is not stalled.
// Reset clears the step counter and the output valid flag; no clearing pass.
// An output stall holds the sequencer on its emit step, or on its sign step for a negative value.
// The next item is accepted while the final character still waits in the output register.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [sida_pkg::ValueW-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sida_pkg::CharW-1:0]         char_code_o,
  output logic                               last_o,
  output logic [sida_pkg::DigW-1:0]          char_count_o
);
  import sida_pkg::*;

  ctrl_t            ctrl;
  status_t          status;
  emit_t            emit;
  logic             out_free;
  logic             out_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic [DigW-1:0]  count_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (ctrl.op != OP_LOAD);

  sida_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  sida_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .value_i  (value_i),
    .status_o (status),
    .emit_o   (emit)
  );

  // Hold the output item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the output payload
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      char_q  <= emit.char_code;
      last_q  <= emit.last;
      count_q <= emit.count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_code_o  = char_q;
  assign last_o       = last_q;
  assign char_count_o = count_q;

  `SIDA_ASSERT(a_last_count, out_valid_o && last_o |-> char_count_o >= 4'd1 && char_count_o <= 4'd11, "bad count on last character")
  `SIDA_ASSERT_NEVER(a_mid_count, out_valid_o && !last_o && char_count_o != 4'd0, "count on a middle character")
  `SIDA_ASSERT_NEVER(a_minus_last, out_valid_o && last_o && char_code_o == CharMinus, "minus sign marked last")
  `SIDA_ASSERT(a_one_item, in_valid_i && !in_stall_o |=> in_stall_o, "item accepted during conversion")

endmodule
